>>> rtl/core/lev_pkg.sv
`timescale 1ns / 1ps

package lev_pkg;

    // Default reference capacity in code points
    localparam int MAX_REF_LEN_DEF = 64;

    localparam int CP_W    = 21;
    localparam int ROW_W   = 8;
    localparam int ROW_MAX = 255;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_END    = 2'd3
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [CP_W-1:0] symbol;
        logic            last;
    } t_in_item;

    typedef struct packed {
        logic [ROW_W-1:0] distance;
        logic             saturated;
        logic             reference_overflowed;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_TAIL,
        S_EMIT
    } t_state;

endpackage

>>> rtl/core/levenshtein_edit_distance.sv
`timescale 1ns / 1ps

// Levenshtein edit distance engine. Load a reference string with op 1 (append
// code point) after op 0 (clear); then send query code points with op 2 and
// mark the final one with last, or send op 3 to end the query (an empty one if
// none is in progress). Each ending item returns one item carrying the distance
// (saturated at 255), a flag that some row value was clamped during this query,
// and a sticky flag that appends were dropped past MAX_REF_LEN since the last
// clear. Clear and append abandon any query in progress. A query element walks
// the dynamic-programming row, held in a single-port-read memory, one entry per
// cycle from entry 0 to L (the stored reference length): read, updated, written
// back. A last element then hands its result to the output register in an emit
// state, which waits while that register is full. Op 3 on a fresh row goes to
// the emit state directly, else via a tail state that reads the final row entry.
// The fresh row (entry j holds min(j, 255)) is never written out: a flag
// substitutes it on read, so there is no clearing pass after reset or a query.
module levenshtein_edit_distance #(
    parameter int MAX_REF_LEN = lev_pkg::MAX_REF_LEN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lev_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lev_pkg::t_out_item o_out_item
);

    localparam int LEN_W  = $clog2(MAX_REF_LEN + 1);
    localparam int REF_AW = (MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1;
    localparam logic [LEN_W-1:0] LenMax = LEN_W'(MAX_REF_LEN);

    // Fresh row value min(j, 255)
    function automatic logic [lev_pkg::ROW_W-1:0] fresh_val(input logic [LEN_W-1:0] j);
        return (32'(j) > 32'(lev_pkg::ROW_MAX)) ? lev_pkg::ROW_W'(lev_pkg::ROW_MAX)
                                                 : lev_pkg::ROW_W'(j);
    endfunction

    // Control state
    lev_pkg::t_state r_state;
    lev_pkg::t_state n_state;
    logic [LEN_W-1:0] r_ref_len;
    logic             r_ref_ovf;
    logic             r_fresh;
    logic             r_sat;
    logic             r_out_valid;

    // Row walk datapath
    logic [LEN_W-1:0]              r_didx;
    logic [lev_pkg::ROW_W-1:0]     r_diag;
    logic [lev_pkg::ROW_W-1:0]     r_left;
    logic [lev_pkg::CP_W-1:0]      r_cp;
    logic                          r_last;
    lev_pkg::t_out_item            r_pend;
    lev_pkg::t_out_item            r_out;

    // Memory ports
    logic                          ref_we;
    logic [REF_AW-1:0]             ref_waddr;
    logic [REF_AW-1:0]             ref_raddr;
    logic [lev_pkg::CP_W-1:0]      ref_rdata;
    logic                          row_we;
    logic [LEN_W-1:0]              row_waddr;
    logic [LEN_W-1:0]              row_raddr;
    logic [lev_pkg::ROW_W-1:0]     row_rdata;

    logic                          in_acc;
    logic                          out_free;
    logic                          sweep_end;
    logic                          is_append;
    logic [lev_pkg::ROW_W-1:0]     old_val;
    logic [lev_pkg::ROW_W-1:0]     cell_value;
    logic                          cell_clamped;
    logic                          len_over_row;

    assign in_acc       = i_in_valid && !o_in_stall;
    assign out_free     = !r_out_valid || !i_out_stall;
    assign sweep_end    = (r_didx == r_ref_len);
    assign is_append    = (i_in_item.op == lev_pkg::OP_APPEND);
    assign len_over_row = (32'(r_ref_len) > 32'(lev_pkg::ROW_MAX));
    // Substitute the fresh row instead of the stored one
    assign old_val      = r_fresh ? fresh_val(r_didx) : row_rdata;

    lev_ram #(
        .WIDTH(lev_pkg::CP_W),
        .DEPTH(MAX_REF_LEN)
    ) u_ref_ram (
        .i_clk  (i_clk),
        .i_we   (ref_we),
        .i_waddr(ref_waddr),
        .i_wdata(i_in_item.symbol),
        .i_raddr(ref_raddr),
        .o_rdata(ref_rdata)
    );

    lev_ram #(
        .WIDTH(lev_pkg::ROW_W),
        .DEPTH(MAX_REF_LEN + 1)
    ) u_row_ram (
        .i_clk  (i_clk),
        .i_we   (row_we),
        .i_waddr(row_waddr),
        .i_wdata(cell_value),
        .i_raddr(row_raddr),
        .o_rdata(row_rdata)
    );

    lev_cell u_cell (
        .i_first   (r_didx == '0),
        .i_mismatch(ref_rdata != r_cp),
        .i_old     (old_val),
        .i_diag    (r_diag),
        .i_left    (r_left),
        .o_value   (cell_value),
        .o_clamped (cell_clamped)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lev_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_in_item.op)
                        lev_pkg::OP_QUERY: n_state = lev_pkg::S_SWEEP;
                        lev_pkg::OP_END:   n_state = r_fresh ? lev_pkg::S_EMIT
                                                             : lev_pkg::S_TAIL;
                        default:           n_state = lev_pkg::S_IDLE;
                    endcase
                end
            end
            lev_pkg::S_SWEEP: begin
                if (sweep_end) begin
                    n_state = r_last ? lev_pkg::S_EMIT : lev_pkg::S_IDLE;
                end
            end
            lev_pkg::S_TAIL: begin
                n_state = lev_pkg::S_EMIT;
            end
            lev_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = lev_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lev_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs and memory addressing
    always_comb begin
        o_in_stall = 1'b1;
        row_raddr  = '0;
        row_we     = 1'b0;
        row_waddr  = r_didx;
        ref_raddr  = r_didx[REF_AW-1:0];
        ref_we     = 1'b0;
        ref_waddr  = r_ref_len[REF_AW-1:0];
        case (r_state)
            lev_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                // Op 3 on a walked row reads the final entry; a query starts at entry zero
                if (i_in_item.op == lev_pkg::OP_END) begin
                    row_raddr = r_ref_len;
                end
                ref_we = in_acc && is_append && (r_ref_len != LenMax);
            end
            lev_pkg::S_SWEEP: begin
                // Prefetch the next entry while writing back this one
                row_raddr = r_didx + LEN_W'(1);
                row_we    = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lev_pkg::S_IDLE;
            r_ref_len   <= '0;
            r_ref_ovf   <= 1'b0;
            r_fresh     <= 1'b1;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                case (i_in_item.op)
                    lev_pkg::OP_CLEAR: begin
                        r_ref_len <= '0;
                        r_ref_ovf <= 1'b0;
                        r_fresh   <= 1'b1;
                        r_sat     <= 1'b0;
                    end
                    lev_pkg::OP_APPEND: begin
                        // Drop the code point once the store is full
                        if (r_ref_len != LenMax) begin
                            r_ref_len <= r_ref_len + LEN_W'(1);
                        end else begin
                            r_ref_ovf <= 1'b1;
                        end
                        r_fresh <= 1'b1;
                        r_sat   <= 1'b0;
                    end
                    default: begin
                        // A fresh row longer than 255 already holds clamped values
                        if (r_fresh && len_over_row) begin
                            r_sat <= 1'b1;
                        end
                    end
                endcase
            end
            if (r_state == lev_pkg::S_SWEEP) begin
                if (cell_clamped) begin
                    r_sat <= 1'b1;
                end
                if (sweep_end) begin
                    r_fresh <= 1'b0;
                end
            end
            if (r_state == lev_pkg::S_EMIT && out_free) begin
                r_fresh     <= 1'b1;
                r_sat       <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cp   <= i_in_item.symbol;
            r_last <= i_in_item.last;
            r_didx <= '0;
            if (i_in_item.op == lev_pkg::OP_END && r_fresh) begin
                r_pend.distance             <= fresh_val(r_ref_len);
                r_pend.saturated            <= len_over_row;
                r_pend.reference_overflowed <= r_ref_ovf;
            end
        end
        case (r_state)
            lev_pkg::S_SWEEP: begin
                r_diag <= old_val;
                r_left <= cell_value;
                if (sweep_end) begin
                    r_pend.distance             <= cell_value;
                    r_pend.saturated            <= r_sat || cell_clamped;
                    r_pend.reference_overflowed <= r_ref_ovf;
                end else begin
                    r_didx <= r_didx + LEN_W'(1);
                end
            end
            lev_pkg::S_TAIL: begin
                r_pend.distance             <= row_rdata;
                r_pend.saturated            <= r_sat;
                r_pend.reference_overflowed <= r_ref_ovf;
            end
            lev_pkg::S_EMIT: begin
                if (out_free) begin
                    r_out <= r_pend;
                end
            end
            default: begin
                r_out <= r_out;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lev_pkg::S_SWEEP) |-> (r_didx <= r_ref_len))
        else $error("row walk index beyond reference length");

    a_ovf_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ref_ovf |-> (r_ref_len == LenMax))
        else $error("overflow flagged while reference store not full");

    a_emit_ends_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lev_pkg::S_EMIT && out_free) |=> (r_fresh && !r_sat && o_out_valid))
        else $error("query state not reset after result handoff");

    a_walk_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lev_pkg::S_SWEEP && !sweep_end) |=>
            (r_state == lev_pkg::S_SWEEP && r_didx == $past(r_didx) + LEN_W'(1)))
        else $error("row walk stalled or skipped an entry");

endmodule

>>> rtl/core/lev_ram.sv
`timescale 1ns / 1ps

module lev_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/lev_cell.sv
`timescale 1ns / 1ps

module lev_cell (
    input  logic                      i_first,
    input  logic                      i_mismatch,
    input  logic [lev_pkg::ROW_W-1:0] i_old,
    input  logic [lev_pkg::ROW_W-1:0] i_diag,
    input  logic [lev_pkg::ROW_W-1:0] i_left,
    output logic [lev_pkg::ROW_W-1:0] o_value,
    output logic                      o_clamped
);

    logic [lev_pkg::ROW_W:0] w_del;
    logic [lev_pkg::ROW_W:0] w_sub;
    logic [lev_pkg::ROW_W:0] w_ins;
    logic [lev_pkg::ROW_W:0] w_best;

    assign w_del = {1'b0, i_old} + (lev_pkg::ROW_W + 1)'(1);
    assign w_sub = {1'b0, i_diag} + (lev_pkg::ROW_W + 1)'(i_mismatch);
    assign w_ins = {1'b0, i_left} + (lev_pkg::ROW_W + 1)'(1);

    // Column zero only grows by one per query element
    always_comb begin
        w_best = w_del;
        if (!i_first) begin
            if (w_sub < w_best) begin
                w_best = w_sub;
            end
            if (w_ins < w_best) begin
                w_best = w_ins;
            end
        end
    end

    assign o_clamped = (w_best > (lev_pkg::ROW_W + 1)'(lev_pkg::ROW_MAX));
    assign o_value   = o_clamped ? lev_pkg::ROW_W'(lev_pkg::ROW_MAX)
                                 : w_best[lev_pkg::ROW_W-1:0];

endmodule

>>> dv/levenshtein_edit_distance_tb.sv
`timescale 1ns / 1ps

// Edit distance engine bench: a class keeps its own copy of the reference string and
// the dynamic-programming row, works out the distance item for every accepted item that
// ends a query, and compares the block's output items in order.
module levenshtein_edit_distance_tb;
    import lev_pkg::*;

    localparam int REF_CAP      = MAX_REF_LEN_DEF;
    localparam int GAP_MAX      = 17;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;
    // Worst item is a query element on a full reference, walked and then emitted.
    localparam int TAIL_CYCLES  = 2 * (REF_CAP + 3);
    localparam int RANDOM_ITEMS = 700;

    class edit_distance_sb;
        logic [CP_W-1:0] ref_cp [REF_CAP];
        int              row [REF_CAP+1];
        int              ref_len;
        bit              overflow;
        bit              fresh;
        bit              sat_seen;
        t_out_item       distances_due [$];
        int              errors;

        function new();
            ref_len  = 0;
            overflow = 1'b0;
            errors   = 0;
            reload_row();
            close_query();
        endfunction

        // Clamp a row value to the row width and remember that it happened.
        function int clamp(int v);
            if (v > ROW_MAX) begin
                sat_seen = 1'b1;
                return ROW_MAX;
            end
            return v;
        endfunction

        function void reload_row();
            for (int j = 0; j <= REF_CAP; j++)
                row[j] = (j > ROW_MAX) ? ROW_MAX : j;
            sat_seen = (ref_len > ROW_MAX);
            fresh    = 1'b0;
        endfunction

        function void close_query();
            fresh    = 1'b1;
            sat_seen = 1'b0;
        endfunction

        function void queue_distance();
            t_out_item d;
            d.distance             = ROW_W'(row[ref_len]);
            d.saturated            = sat_seen;
            d.reference_overflowed = overflow;
            distances_due = {distances_due, d};
        endfunction

        // Advance the edit-distance state by one accepted item.
        function void apply_item(t_in_item it);
            int diag;
            int via_sub;
            int via_del;
            int via_ins;
            int best;
            case (it.op)
                OP_CLEAR: begin
                    ref_len  = 0;
                    overflow = 1'b0;
                    close_query();
                end
                OP_APPEND: begin
                    if (ref_len < REF_CAP) begin
                        ref_cp[ref_len] = it.symbol;
                        ref_len++;
                    end else begin
                        overflow = 1'b1;
                    end
                    close_query();
                end
                OP_QUERY: begin
                    if (fresh)
                        reload_row();
                    // Walk the row in place; diag holds the previous row's entry j.
                    diag   = row[0];
                    row[0] = clamp(row[0] + 1);
                    for (int j = 0; j < ref_len; j++) begin
                        via_sub = diag + ((ref_cp[j] == it.symbol) ? 0 : 1);
                        via_del = row[j+1] + 1;
                        via_ins = row[j] + 1;
                        best    = via_sub;
                        if (via_del < best) best = via_del;
                        if (via_ins < best) best = via_ins;
                        diag     = row[j+1];
                        row[j+1] = clamp(best);
                    end
                    if (it.last) begin
                        queue_distance();
                        close_query();
                    end
                end
                OP_END: begin
                    if (fresh)
                        reload_row();
                    queue_distance();
                    close_query();
                end
            endcase
        endfunction

        function void compare_distance(t_out_item got);
            t_out_item want;
            if (distances_due.size() == 0) begin
                $error("unexpected result item: distance %0d", got.distance);
                errors++;
                return;
            end
            want = distances_due.pop_front();
            if (got.distance !== want.distance) begin
                $error("distance: expected %0d, got %0d", want.distance, got.distance);
                errors++;
            end
            if (got.saturated !== want.saturated) begin
                $error("saturated: expected %0d, got %0d", want.saturated, got.saturated);
                errors++;
            end
            if (got.reference_overflowed !== want.reference_overflowed) begin
                $error("reference_overflowed: expected %0d, got %0d",
                       want.reference_overflowed, got.reference_overflowed);
                errors++;
            end
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    edit_distance_sb sb;

    bit              send_gaps;
    bit              recv_gaps;
    int              items_sent;
    int              results_seen;
    int              quiet;
    // Mirror of the stored reference, used to draw query symbols that match.
    logic [CP_W-1:0] ref_text [$];
    // Small per-sequence alphabet so that references and queries share symbols.
    logic [CP_W-1:0] letters [4];

    levenshtein_edit_distance i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Offer one item after a drawn gap; hold it until the block takes it.
    task automatic send_item(t_op kind, logic [CP_W-1:0] cp, logic fin);
        int gap;
        if ($urandom_range(0, 29) == 0)
            send_gaps = !send_gaps;
        gap = send_gaps ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{op: kind, symbol: cp, last: fin};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.apply_item(in_item);
        items_sent++;
        if (kind == OP_CLEAR)
            ref_text.delete();
        else if (kind == OP_APPEND && ref_text.size() < REF_CAP)
            ref_text = {ref_text, cp};
    endtask

    function automatic logic [CP_W-1:0] pick_symbol();
        case ($urandom_range(0, 3))
            0:       return CP_W'($urandom);
            1:       return letters[$urandom_range(0, 3)];
            default: return (ref_text.size() > 0) ?
                            ref_text[$urandom_range(0, ref_text.size() - 1)] :
                            letters[$urandom_range(0, 3)];
        endcase
    endfunction

    // Clear (unless appending onto what is stored) and append n code points.
    task automatic load_reference(int n, bit keep);
        if (!keep)
            send_item(OP_CLEAR, CP_W'($urandom), 1'($urandom));
        for (int k = 0; k < n; k++)
            send_item(OP_APPEND,
                      ($urandom_range(0, 3) == 0) ? CP_W'($urandom) : letters[$urandom_range(0, 3)],
                      1'($urandom));
    endtask

    // Send n query elements; end with last on the final one, or with an end command.
    task automatic run_query(int n, bit end_cmd);
        for (int k = 0; k < n; k++)
            send_item(OP_QUERY, pick_symbol(), (k == n - 1) && !end_cmd);
        if (n == 0 || end_cmd)
            send_item(OP_END, CP_W'($urandom), 1'($urandom));
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.compare_distance(out_item);
            results_seen++;
        end
    end

    // Count cycles in which no item moves on either side.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    initial begin
        @(posedge clk);
        while (quiet < QUIET_LIMIT) @(posedge clk);
        $error("no item moved for %0d cycles", QUIET_LIMIT);
        $display("levenshtein_edit_distance_tb: done, errors");
        $finish;
    end

    // Receiver: stall a drawn number of cycles per item, and once hold off long enough
    // that the output register fills and the block stalls its input.
    initial begin
        int stall_cycles;
        bit held;
        held = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if ($urandom_range(0, 29) == 0)
                recv_gaps = !recv_gaps;
            stall_cycles = recv_gaps ? $urandom_range(0, GAP_MAX) : 0;
            if (!held && results_seen >= 12) begin
                stall_cycles += HOLD_CYCLES;
                held = 1'b1;
            end
            if (stall_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin
        int directed_count;
        int seq;
        int n_ref;
        int n_q;
        int pick;
        sb = new();
        for (int i = 0; i < 4; i++)
            letters[i] = CP_W'($urandom);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty query on a fresh row, then a one-element query, both on an empty reference.
        send_item(OP_END,    21'h000000, 1'b0);
        send_item(OP_QUERY,  21'h000000, 1'b1);
        // Clear with last set: last is ignored outside queries.
        send_item(OP_CLEAR,  21'h1FFFFF, 1'b1);
        send_item(OP_APPEND, 21'h000000, 1'b0);
        send_item(OP_APPEND, 21'h1FFFFF, 1'b1);
        send_item(OP_APPEND, 21'h10FFFF, 1'b0);
        // Code points above the Unicode range are plain symbols.
        send_item(OP_QUERY,  21'h1FFFFF, 1'b0);
        send_item(OP_QUERY,  21'h000000, 1'b0);
        send_item(OP_QUERY,  21'h10FFFF, 1'b1);
        // End command during a query reports the distance so far.
        send_item(OP_QUERY,  21'h10FFFF, 1'b0);
        send_item(OP_END,    21'h0F0F0F, 1'b0);
        // End command on a fresh row reports the reference length.
        send_item(OP_END,    21'h000000, 1'b1);
        // Append mid-query abandons the query.
        send_item(OP_QUERY,  21'h000001, 1'b0);
        send_item(OP_APPEND, 21'h0ABCDE, 1'b0);
        send_item(OP_QUERY,  21'h1FFFFF, 1'b1);
        // Clear mid-query abandons it as well.
        send_item(OP_QUERY,  21'h155555, 1'b0);
        send_item(OP_CLEAR,  21'h0AAAAA, 1'b0);
        send_item(OP_END,    21'h155555, 1'b0);
        send_item(OP_QUERY,  21'h0AAAAA, 1'b1);
        directed_count = items_sent;

        // Mostly well-formed sequences: a reference load followed by a few queries,
        // with abandoned queries and raw noise mixed in.
        seq = 0;
        while (items_sent < directed_count + RANDOM_ITEMS) begin
            for (int i = 0; i < 4; i++)
                letters[i] = CP_W'($urandom);
            pick = $urandom_range(0, 19);
            if (seq == 1)
                n_ref = $urandom_range(0, 3);
            else if (pick == 0)
                n_ref = 0;
            else if (pick == 1)
                n_ref = REF_CAP;
            else if (pick == 2)
                n_ref = REF_CAP + $urandom_range(1, 6);
            else
                n_ref = $urandom_range(1, 12);
            load_reference(n_ref, seq != 1 && $urandom_range(0, 4) == 0);
            // One query long enough to push the row past 255 and saturate.
            if (seq == 1)
                run_query($urandom_range(256, 262), 1'($urandom));
            n_q = $urandom_range(1, 5);
            for (int q = 0; q < n_q; q++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        repeat ($urandom_range(1, 6))
                            send_item(OP_QUERY, pick_symbol(), 1'b0);
                        send_item($urandom_range(0, 1) ? OP_APPEND : OP_CLEAR,
                                  pick_symbol(), 1'($urandom));
                    end
                    1: begin
                        repeat ($urandom_range(1, 4))
                            send_item(t_op'($urandom_range(0, 3)), CP_W'($urandom),
                                      1'($urandom));
                    end
                    default: run_query($urandom_range(0, 14), $urandom_range(0, 3) == 0);
                endcase
            end
            seq++;
        end
        in_valid <= 1'b0;

        // Drain, then give a last item without a result time to finish.
        while (sb.distances_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("levenshtein_edit_distance_tb: done, clean");
        else
            $display("levenshtein_edit_distance_tb: done, errors");
        $finish;
    end

endmodule
